FILE: rtl/core/vss_pkg.sv
package vss_pkg;

  // Fixed field widths
  localparam int unsigned DacBitsDef = 16;
  localparam int unsigned StepW      = 10;
  localparam int unsigned PeriodW    = 10;
  localparam int unsigned IncW       = 16;
  localparam int unsigned BlkW       = 17;
  localparam int unsigned AccW       = 18;
  localparam int unsigned SampleW    = 16;
  localparam int unsigned ModeW      = 3;
  localparam int unsigned CfgIdxW    = 3;
  localparam int unsigned CfgDataW   = 16;

  // Limits and reset values
  localparam logic [StepW-1:0]   MaxSteps       = 10'd1000;
  localparam logic [PeriodW-1:0] PeriodMin      = 10'd15;
  localparam logic [PeriodW-1:0] PeriodMax      = 10'd1000;
  localparam logic [PeriodW-1:0] BasePeriodRst  = 10'd25;
  localparam logic [IncW-1:0]    RefStepOddRst  = 16'd29;
  localparam int unsigned        RefLevelRst    = 6581;
  localparam int unsigned        WorkLevelRst   = 21081;

  typedef enum logic [ModeW-1:0] {
    ModeTick    = 3'd0,
    ModeStart   = 3'd1,
    ModeHalt    = 3'd2,
    ModeSetRef  = 3'd3,
    ModeSetWork = 3'd4
  } mode_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgRefStepOdd   = 3'd0,
    CfgRefStepEven  = 3'd1,
    CfgWorkStepOdd  = 3'd2,
    CfgWorkStepEven = 3'd3,
    CfgStepLimit    = 3'd4,
    CfgBasePeriod   = 3'd5,
    CfgPulsePeriod  = 3'd6
  } cfg_idx_e;

  // Register file contents plus the base-period load strobe and value
  typedef struct packed {
    logic [IncW-1:0]    ref_step_odd;
    logic [IncW-1:0]    ref_step_even;
    logic [IncW-1:0]    work_step_odd;
    logic [IncW-1:0]    work_step_even;
    logic [StepW-1:0]   step_limit;
    logic [PeriodW-1:0] base_period;
    logic [PeriodW-1:0] pulse_period;
    logic               period_load;
    logic [PeriodW-1:0] period_value;
  } cfg_t;

  // Result fields that do not scale with the DAC width
  typedef struct packed {
    logic               levels_changed;
    logic [SampleW-1:0] odd_sample;
    logic [SampleW-1:0] even_sample;
    logic               pair_ready;
    logic [StepW-1:0]   pair_step;
    logic               scan_running;
    logic               scan_done;
    logic [PeriodW-1:0] period_ms;
  } status_t;

  function automatic logic [PeriodW-1:0] clamp_period(logic [PeriodW-1:0] v);
    logic [PeriodW-1:0] r;
    r = v;
    if (v < PeriodMin) r = PeriodMin;
    else if (v > PeriodMax) r = PeriodMax;
    return r;
  endfunction

endpackage

FILE: rtl/core/vss_cfg_regs.sv
module vss_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          wr_en_i,
  input  logic [vss_pkg::CfgIdxW-1:0]   wr_idx_i,
  input  logic [vss_pkg::CfgDataW-1:0]  wr_data_i,
  output vss_pkg::cfg_t                 cfg_o
);
  import vss_pkg::*;

  logic [IncW-1:0]    ref_odd_q, ref_even_q, work_odd_q, work_even_q;
  logic [StepW-1:0]   limit_q;
  logic [PeriodW-1:0] base_q, pulse_q;

  logic [PeriodW-1:0] v10;
  logic [StepW-1:0]   limit_clamped;
  logic [PeriodW-1:0] period_clamped;
  logic               base_wr;

  assign v10            = wr_data_i[PeriodW-1:0];
  assign period_clamped = clamp_period(v10);
  assign base_wr        = wr_en_i && (wr_idx_i == CfgBasePeriod);

  always_comb begin
    limit_clamped = wr_data_i[StepW-1:0];
    if (limit_clamped == '0) limit_clamped = StepW'(1);
    else if (limit_clamped > MaxSteps) limit_clamped = MaxSteps;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_odd_q   <= RefStepOddRst;
      ref_even_q  <= '0;
      work_odd_q  <= '0;
      work_even_q <= '0;
      limit_q     <= MaxSteps;
      base_q      <= BasePeriodRst;
      pulse_q     <= '0;
    end else if (wr_en_i) begin
      case (wr_idx_i)
        CfgRefStepOdd:   ref_odd_q   <= wr_data_i;
        CfgRefStepEven:  ref_even_q  <= wr_data_i;
        CfgWorkStepOdd:  work_odd_q  <= wr_data_i;
        CfgWorkStepEven: work_even_q <= wr_data_i;
        CfgStepLimit:    limit_q     <= limit_clamped;
        CfgBasePeriod:   base_q      <= period_clamped;
        CfgPulsePeriod:  pulse_q     <= (v10 == '0) ? '0 : period_clamped;
        default: ;
      endcase
    end
  end

  assign cfg_o.ref_step_odd   = ref_odd_q;
  assign cfg_o.ref_step_even  = ref_even_q;
  assign cfg_o.work_step_odd  = work_odd_q;
  assign cfg_o.work_step_even = work_even_q;
  assign cfg_o.step_limit     = limit_q;
  assign cfg_o.base_period    = base_q;
  assign cfg_o.pulse_period   = pulse_q;
  assign cfg_o.period_load    = base_wr;
  assign cfg_o.period_value   = period_clamped;

endmodule

FILE: rtl/core/vss_engine.sv
module vss_engine #(
  parameter int unsigned DAC_BITS = vss_pkg::DacBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          fire_i,
  input  logic [vss_pkg::ModeW-1:0]     mode_i,
  input  logic [vss_pkg::BlkW-1:0]      blk_i,
  input  logic [DAC_BITS-1:0]           lvl_i,
  input  vss_pkg::cfg_t                 cfg_i,
  output logic [DAC_BITS-1:0]           ref_level_o,
  output logic [DAC_BITS-1:0]           work_level_o,
  output vss_pkg::status_t              status_o
);
  import vss_pkg::*;

  localparam int unsigned SumW = ((DAC_BITS > IncW + 1) ? DAC_BITS : IncW + 1) + 2;

  logic               half_q, half_d;
  logic [AccW-1:0]    acc_q, acc_d;
  logic [DAC_BITS-1:0] ref_q, ref_d, work_q, work_d;
  logic [StepW-1:0]   step_q, step_d;
  logic               run_q, run_d;
  logic               flip_q, flip_d;
  logic [SampleW-1:0] odd_q, odd_d, even_q, even_d;
  logic [StepW-1:0]   pstep_q, pstep_d;
  logic [PeriodW-1:0] period_q, period_d;

  logic               changed, ready, done;
  logic [AccW-1:0]    sum;
  logic [StepW-1:0]   step_inc, mid_step;
  logic               even;
  logic [IncW-1:0]    ri_sel, wi_sel;
  logic signed [IncW:0] ri, wi;
  logic               dpv_on;

  // Level plus signed increment, clipped to the DAC range
  function automatic logic [DAC_BITS-1:0] sat_add(logic [DAC_BITS-1:0] lvl,
                                                  logic signed [IncW:0] inc);
    logic signed [SumW-1:0] t;
    logic [DAC_BITS-1:0]    r;
    t = $signed({{(SumW-DAC_BITS){1'b0}}, lvl}) + $signed({{(SumW-IncW-1){inc[IncW]}}, inc});
    if (t[SumW-1]) r = '0;
    else if (|t[SumW-2:DAC_BITS]) r = '1;
    else r = t[DAC_BITS-1:0];
    return r;
  endfunction

  assign sum      = acc_q + AccW'(blk_i);
  assign step_inc = step_q + StepW'(1);
  assign mid_step = (cfg_i.step_limit >> 1) + StepW'(1);
  assign dpv_on   = (cfg_i.pulse_period != '0);

  always_comb begin
    half_d   = half_q;
    acc_d    = acc_q;
    ref_d    = ref_q;
    work_d   = work_q;
    step_d   = step_q;
    run_d    = run_q;
    flip_d   = flip_q;
    odd_d    = odd_q;
    even_d   = even_q;
    pstep_d  = pstep_q;
    period_d = period_q;
    changed  = 1'b0;
    ready    = 1'b0;
    done     = 1'b0;
    even     = 1'b0;
    ri_sel   = '0;
    wi_sel   = '0;
    ri       = '0;
    wi       = '0;
    case (mode_i)
      ModeTick: begin
        half_d = ~half_q;
        if (!half_q) begin
          // main half: close the sample, advance the scan
          if (run_q) begin
            step_d = step_inc;
            if (step_inc > cfg_i.step_limit) begin
              run_d = 1'b0;
              done  = 1'b1;
            end
            if (step_inc == mid_step) flip_d = ~flip_q;
          end
          if (run_d) begin
            even   = ~step_d[0];
            ri_sel = even ? cfg_i.ref_step_even : cfg_i.ref_step_odd;
            wi_sel = even ? cfg_i.work_step_even : cfg_i.work_step_odd;
            ri     = $signed({ri_sel[IncW-1], ri_sel});
            wi     = $signed({wi_sel[IncW-1], wi_sel});
            if (flip_d) ri = -ri;
            ref_d   = sat_add(ref_q, ri);
            work_d  = sat_add(work_q, wi);
            changed = 1'b1;
            if (even) begin
              even_d  = sum[AccW-1:2];
              pstep_d = step_q;
              ready   = 1'b1;
              if (dpv_on) period_d = cfg_i.base_period;
            end else begin
              odd_d = sum[AccW-1:2];
              if (dpv_on) period_d = cfg_i.pulse_period;
            end
          end
          if (done && dpv_on) period_d = cfg_i.base_period;
          acc_d = '0;
        end else begin
          acc_d = sum;
        end
      end
      ModeStart: begin
        run_d  = 1'b1;
        step_d = '0;
      end
      ModeHalt: begin
        run_d  = 1'b0;
        step_d = '0;
        if (dpv_on) period_d = cfg_i.base_period;
      end
      ModeSetRef: begin
        ref_d   = lvl_i;
        changed = 1'b1;
      end
      ModeSetWork: begin
        work_d  = lvl_i;
        changed = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_q   <= 1'b0;
      acc_q    <= '0;
      ref_q    <= DAC_BITS'(RefLevelRst);
      work_q   <= DAC_BITS'(WorkLevelRst);
      step_q   <= '0;
      run_q    <= 1'b0;
      flip_q   <= 1'b0;
      odd_q    <= '0;
      even_q   <= '0;
      pstep_q  <= '0;
      period_q <= BasePeriodRst;
    end else begin
      if (fire_i) begin
        half_q  <= half_d;
        acc_q   <= acc_d;
        ref_q   <= ref_d;
        work_q  <= work_d;
        step_q  <= step_d;
        run_q   <= run_d;
        flip_q  <= flip_d;
        odd_q   <= odd_d;
        even_q  <= even_d;
        pstep_q <= pstep_d;
      end
      if (cfg_i.period_load) period_q <= cfg_i.period_value;
      else if (fire_i) period_q <= period_d;
    end
  end

  assign ref_level_o             = ref_d;
  assign work_level_o            = work_d;
  assign status_o.levels_changed = changed;
  assign status_o.odd_sample     = odd_d;
  assign status_o.even_sample    = even_d;
  assign status_o.pair_ready     = ready;
  assign status_o.pair_step      = pstep_d;
  assign status_o.scan_running   = run_d;
  assign status_o.scan_done      = done;
  assign status_o.period_ms      = period_d;

  // The step counter only moves while a scan runs or on start and halt
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && !run_q && mode_i != ModeStart && mode_i != ModeHalt |=> $stable(step_q))
    else $error("step count moved outside a scan");

  // The count stops one past the limit, and the limit never exceeds its maximum
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_q <= MaxSteps + StepW'(1))
    else $error("step count past its largest value");

  // The accumulator is cleared whenever the main half is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && mode_i == ModeTick && !half_q |=> acc_q == '0 && half_q)
    else $error("accumulator not cleared on main half");

endmodule

FILE: rtl/core/voltammetry_scan_sequencer_core.sv
// Path: an accepted beat goes from the input register to the result register.
// Throughput: one beat per cycle unless the output stalls; each step is one
//   pass of logic from input register through state update to result register.
// Reset (rst_ni low, asynchronous): scan idle, DAC levels 6581 / 21081,
//   config registers at their defaults, both pipeline registers empty.
module voltammetry_scan_sequencer_core #(
  parameter int unsigned DAC_BITS = vss_pkg::DacBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // input channel
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [vss_pkg::ModeW-1:0]     mode_i,
  input  logic [vss_pkg::BlkW-1:0]      adc_block_sum_i,
  input  logic [DAC_BITS-1:0]           level_value_i,
  // configuration write channel
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [vss_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [vss_pkg::CfgDataW-1:0]  cfg_data_i,
  // result channel
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [DAC_BITS-1:0]           ref_level_o,
  output logic [DAC_BITS-1:0]           work_level_o,
  output logic                          levels_changed_o,
  output logic [vss_pkg::SampleW-1:0]   odd_sample_o,
  output logic [vss_pkg::SampleW-1:0]   even_sample_o,
  output logic                          pair_ready_o,
  output logic [vss_pkg::StepW-1:0]     pair_step_o,
  output logic                          scan_running_o,
  output logic                          scan_done_o,
  output logic [vss_pkg::PeriodW-1:0]   period_ms_o
);
  import vss_pkg::*;

  // Input register: holds one beat until the result register can take it.
  logic                 in_vld_q;
  logic [ModeW-1:0]     mode_q;
  logic [BlkW-1:0]      blk_q;
  logic [DAC_BITS-1:0]  lvl_q;

  // Result register
  logic                 out_vld_q;
  logic [DAC_BITS-1:0]  ref_q, work_q;
  status_t              status_q;

  logic                 in_take;
  logic                 fire;
  logic [DAC_BITS-1:0]  ref_nxt, work_nxt;
  status_t              status_nxt;
  cfg_t                 cfg;

  // Step the engine when a beat is waiting and the result slot frees up
  // this cycle (empty, or being drained downstream).
  assign fire       = in_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o = in_vld_q && !fire;
  assign in_take    = in_valid_i && !in_stall_o;

  // The user must write only with the datapath idle; unchecked, always taken.
  assign cfg_ready_o = 1'b1;

  vss_cfg_regs u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (cfg_valid_i && cfg_ready_o),
    .wr_idx_i  (cfg_index_i),
    .wr_data_i (cfg_data_i),
    .cfg_o     (cfg)
  );

  vss_engine #(
    .DAC_BITS (DAC_BITS)
  ) u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fire_i       (fire),
    .mode_i       (mode_q),
    .blk_i        (blk_q),
    .lvl_i        (lvl_q),
    .cfg_i        (cfg),
    .ref_level_o  (ref_nxt),
    .work_level_o (work_nxt),
    .status_o     (status_nxt)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_take) in_vld_q <= 1'b1;
      else if (fire) in_vld_q <= 1'b0;
      if (fire) out_vld_q <= 1'b1;
      else if (!out_stall_i) out_vld_q <= 1'b0;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      mode_q <= mode_i;
      blk_q  <= adc_block_sum_i;
      lvl_q  <= level_value_i;
    end
    if (fire) begin
      ref_q    <= ref_nxt;
      work_q   <= work_nxt;
      status_q <= status_nxt;
    end
  end

  assign out_valid_o      = out_vld_q;
  assign ref_level_o      = ref_q;
  assign work_level_o     = work_q;
  assign levels_changed_o = status_q.levels_changed;
  assign odd_sample_o     = status_q.odd_sample;
  assign even_sample_o    = status_q.even_sample;
  assign pair_ready_o     = status_q.pair_ready;
  assign pair_step_o      = status_q.pair_step;
  assign scan_running_o   = status_q.scan_running;
  assign scan_done_o      = status_q.scan_done;
  assign period_ms_o      = status_q.period_ms;

  // Finishing a scan never moves the DAC levels
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && status_q.scan_done |-> !status_q.scan_running && !status_q.levels_changed)
    else $error("scan end beat shows a running scan or a level change");

  // A completed pair always comes from a live scan step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && status_q.pair_ready |-> status_q.levels_changed && status_q.scan_running)
    else $error("pair ready without a scan step");

  // A beat held back by a stalled output stays in the input register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_vld_q && !fire |=> in_vld_q && $stable(mode_q) && $stable(blk_q))
    else $error("waiting input beat lost");

  // The programmed period always lies in its legal range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> status_q.period_ms >= PeriodMin && status_q.period_ms <= PeriodMax)
    else $error("tick period out of range");

endmodule
